/* design/sgv_pkg.sv */
// Shared types, constants and the arctangent table for the sphere grid vertex generator.
`timescale 1ns / 1ps
package sgv_pkg;

    localparam int DIV_W     = 11;  // divisor and remainder width
    localparam int DIV_STEPS = 43;  // quotient bits produced by the phase divider
    localparam int PH_W      = 32;  // phase width, 2^-32 turn per LSB
    localparam int CW        = 34;  // CORDIC datapath width, Q4.30
    localparam int IDX_W     = 11;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DW    = 32;

    localparam logic signed [CW-1:0] CORDIC_GAIN = 34'sd652032874;
    localparam logic signed [31:0]   ONE_Q30     = 32'sd1073741824;

    localparam logic [CFG_IDX_W-1:0] CFG_CENTER_X = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CENTER_Y = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CENTER_Z = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_RADIUS   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_UDIV     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_VDIV     = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_POLE     = 3'd6;

    typedef logic signed [CW-1:0] t_cval;

    typedef struct packed {
        logic at_north;
        logic at_south;
    } t_pole;

    // Rotation angle of CORDIC step k, in 2^-32 turn.
    function automatic t_cval atan_turn(input int k);
        t_cval a;
        case (k)
            0:  a = 34'sd536870912;
            1:  a = 34'sd316933406;
            2:  a = 34'sd167458907;
            3:  a = 34'sd85004756;
            4:  a = 34'sd42667331;
            5:  a = 34'sd21354465;
            6:  a = 34'sd10679838;
            7:  a = 34'sd5340245;
            8:  a = 34'sd2670163;
            9:  a = 34'sd1335087;
            10: a = 34'sd667544;
            11: a = 34'sd333772;
            12: a = 34'sd166886;
            13: a = 34'sd83443;
            14: a = 34'sd41722;
            15: a = 34'sd20861;
            16: a = 34'sd10430;
            17: a = 34'sd5215;
            18: a = 34'sd2608;
            19: a = 34'sd1304;
            20: a = 34'sd652;
            21: a = 34'sd326;
            22: a = 34'sd163;
            23: a = 34'sd81;
            24: a = 34'sd41;
            25: a = 34'sd20;
            26: a = 34'sd10;
            27: a = 34'sd5;
            28: a = 34'sd3;
            29: a = 34'sd1;
            30: a = 34'sd1;
            default: a = 34'sd0;
        endcase
        return a;
    endfunction

endpackage

/* design/sgv_div_cell.sv */
// One restoring-division cell: produces one quotient bit of the phase and hands on.
`timescale 1ns / 1ps
module sgv_div_cell (
    input  logic                          i_clk,
    input  logic                          i_en,
    input  logic [sgv_pkg::DIV_W-1:0]     i_rem,
    input  logic [sgv_pkg::DIV_STEPS-1:0] i_num,
    input  logic [sgv_pkg::PH_W-1:0]      i_quo,
    input  logic [sgv_pkg::DIV_W-1:0]     i_div,
    output logic [sgv_pkg::DIV_W-1:0]     o_rem,
    output logic [sgv_pkg::DIV_STEPS-1:0] o_num,
    output logic [sgv_pkg::PH_W-1:0]      o_quo,
    output logic [sgv_pkg::DIV_W-1:0]     o_div
);
    import sgv_pkg::*;

    logic [DIV_W:0]   w_trial;
    logic             w_fits;
    logic [DIV_W-1:0] n_rem;
    logic [DIV_W:0]   w_diff;

    logic [DIV_W-1:0]     r_rem;
    logic [DIV_STEPS-1:0] r_num;
    logic [PH_W-1:0]      r_quo;
    logic [DIV_W-1:0]     r_div;

    always_comb begin
        w_trial = {i_rem, i_num[DIV_STEPS-1]};
        w_diff  = w_trial - {1'b0, i_div};
        w_fits  = (w_trial >= {1'b0, i_div});
        // The remainder stays below the divisor, so it fits the narrow width.
        n_rem   = w_fits ? w_diff[DIV_W-1:0] : w_trial[DIV_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem <= n_rem;
            r_num <= {i_num[DIV_STEPS-2:0], 1'b0};
            r_quo <= {i_quo[PH_W-2:0], w_fits};
            r_div <= i_div;
        end
    end

    assign o_rem = r_rem;
    assign o_num = r_num;
    assign o_quo = r_quo;
    assign o_div = r_div;

endmodule

/* design/sgv_cordic_cell.sv */
// One CORDIC rotation cell with a fixed shift and angle.
`timescale 1ns / 1ps
module sgv_cordic_cell #(
    parameter int STAGE = 0
) (
    input  logic                i_clk,
    input  logic                i_en,
    input  sgv_pkg::t_cval      i_x,
    input  sgv_pkg::t_cval      i_y,
    input  sgv_pkg::t_cval      i_z,
    input  logic [1:0]          i_quad,
    output sgv_pkg::t_cval      o_x,
    output sgv_pkg::t_cval      o_y,
    output sgv_pkg::t_cval      o_z,
    output logic [1:0]          o_quad
);
    import sgv_pkg::*;

    localparam t_cval ANGLE = atan_turn(STAGE);

    t_cval w_xs, w_ys;
    t_cval n_x, n_y, n_z;
    t_cval r_x, r_y, r_z;
    logic [1:0] r_quad;

    always_comb begin
        w_xs = i_x >>> STAGE;
        w_ys = i_y >>> STAGE;
        if (!i_z[CW-1]) begin
            n_x = i_x - w_ys;
            n_y = i_y + w_xs;
            n_z = i_z - ANGLE;
        end else begin
            n_x = i_x + w_ys;
            n_y = i_y - w_xs;
            n_z = i_z + ANGLE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x    <= n_x;
            r_y    <= n_y;
            r_z    <= n_z;
            r_quad <= i_quad;
        end
    end

    assign o_x    = r_x;
    assign o_y    = r_y;
    assign o_z    = r_z;
    assign o_quad = r_quad;

endmodule

/* design/sphere_grid_vertex_generator.sv */
// Throughput: one request per cycle while the skid entry is empty; the rate is set by the
// 43-cell phase divider chain and the CORDIC_STAGES-cell rotation chain, each cell passing
// its work on every cycle in which the skid entry is empty.
// An output register with one skid entry behind it keeps input ready free of output ready.
// Reset (synchronous, active low) clears all valid bits and restores the register defaults.
`timescale 1ns / 1ps
module sphere_grid_vertex_generator #(
    parameter int MAX_DIVISIONS = 1024,
    parameter int CORDIC_STAGES = 16
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_wr_en,
    input  logic [sgv_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [sgv_pkg::CFG_DW-1:0]       i_cfg_data,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // [10:0] longitude_index, [21:11] latitude_index, [23:22] zero
    input  logic [23:0]                      s_axis_tdata,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // [31:0] position_x, [63:32] position_y, [95:64] position_z,
    // [111:96] normal_x, [127:112] normal_y, [143:128] normal_z
    output logic [143:0]                     m_axis_tdata
);
    import sgv_pkg::*;

    localparam int NC = CORDIC_STAGES;

    // Configuration registers
    logic signed [31:0] r_center_x, r_center_y, r_center_z;
    logic [30:0]        r_radius;
    logic [10:0]        r_udiv, r_vdiv;
    logic               r_pole;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_center_x <= '0;
            r_center_y <= '0;
            r_center_z <= '0;
            r_radius   <= 31'd65536;
            r_udiv     <= 11'd16;
            r_vdiv     <= 11'd8;
            r_pole     <= 1'b0;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                CFG_CENTER_X: r_center_x <= i_cfg_data;
                CFG_CENTER_Y: r_center_y <= i_cfg_data;
                CFG_CENTER_Z: r_center_z <= i_cfg_data;
                CFG_RADIUS:   r_radius   <= i_cfg_data[30:0];
                CFG_UDIV:     r_udiv     <= i_cfg_data[10:0];
                CFG_VDIV:     r_vdiv     <= i_cfg_data[10:0];
                CFG_POLE:     r_pole     <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    function automatic logic [DIV_W-1:0] eff_div(input logic [10:0] d);
        logic [DIV_W-1:0] e;
        if (d == '0)
            e = 11'd1;
        else if (32'(d) > MAX_DIVISIONS)
            e = 11'(MAX_DIVISIONS);
        else
            e = d;
        return e;
    endfunction

    // Pipeline control: everything advances unless the skid entry is occupied.
    logic r_sk_v, r_out_v;
    logic w_en, w_acc;

    assign w_en          = !r_sk_v;
    assign s_axis_tready = w_en;
    assign w_acc         = s_axis_tvalid && w_en;

    logic [IDX_W-1:0] w_li, w_lj;
    logic [DIV_W-1:0] w_ud, w_vd;
    t_pole            w_pole_in;

    assign w_li = s_axis_tdata[10:0];
    assign w_lj = s_axis_tdata[21:11];
    assign w_ud = eff_div(r_udiv);
    assign w_vd = eff_div(r_vdiv);
    assign w_pole_in.at_north = r_pole && (w_lj == '0);
    assign w_pole_in.at_south = r_pole && (w_lj != '0) && (w_lj == w_vd);

    // Phase divider chain, one lane for longitude and one for latitude
    logic [DIV_W-1:0]     ur_rem [DIV_STEPS+1];
    logic [DIV_STEPS-1:0] ur_num [DIV_STEPS+1];
    logic [PH_W-1:0]      ur_quo [DIV_STEPS+1];
    logic [DIV_W-1:0]     ur_div [DIV_STEPS+1];
    logic [DIV_W-1:0]     vr_rem [DIV_STEPS+1];
    logic [DIV_STEPS-1:0] vr_num [DIV_STEPS+1];
    logic [PH_W-1:0]      vr_quo [DIV_STEPS+1];
    logic [DIV_W-1:0]     vr_div [DIV_STEPS+1];

    assign ur_rem[0] = '0;
    assign ur_num[0] = {w_li, 32'd0};
    assign ur_quo[0] = '0;
    assign ur_div[0] = w_ud;
    assign vr_rem[0] = '0;
    assign vr_num[0] = {1'b0, w_lj, 31'd0};
    assign vr_quo[0] = '0;
    assign vr_div[0] = w_vd;

    for (genvar s = 0; s < DIV_STEPS; s++) begin : g_div
        sgv_div_cell u_ucell (
            .i_clk (i_clk), .i_en (w_en),
            .i_rem (ur_rem[s]), .i_num (ur_num[s]), .i_quo (ur_quo[s]), .i_div (ur_div[s]),
            .o_rem (ur_rem[s+1]), .o_num (ur_num[s+1]), .o_quo (ur_quo[s+1]),
            .o_div (ur_div[s+1])
        );
        sgv_div_cell u_vcell (
            .i_clk (i_clk), .i_en (w_en),
            .i_rem (vr_rem[s]), .i_num (vr_num[s]), .i_quo (vr_quo[s]), .i_div (vr_div[s]),
            .o_rem (vr_rem[s+1]), .o_num (vr_num[s+1]), .o_quo (vr_quo[s+1]),
            .o_div (vr_div[s+1])
        );
    end

    logic [DIV_STEPS-1:0] r_dv;
    t_pole                r_dp [DIV_STEPS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dv <= '0;
        end else if (w_en) begin
            r_dv <= {r_dv[DIV_STEPS-2:0], w_acc};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_dp[0] <= w_pole_in;
            for (int s = 1; s < DIV_STEPS; s++) r_dp[s] <= r_dp[s-1];
        end
    end

    logic [PH_W-1:0] w_uph, w_vph;
    always_comb begin
        w_uph = ur_quo[DIV_STEPS];
        if (r_dp[DIV_STEPS-1].at_north)
            w_vph = 32'h0000_0001;
        else if (r_dp[DIV_STEPS-1].at_south)
            w_vph = 32'h7FFF_FFFF;
        else
            w_vph = vr_quo[DIV_STEPS];
    end

    // CORDIC chains
    t_cval      ux [NC+1], uy [NC+1], uz [NC+1];
    t_cval      vx [NC+1], vy [NC+1], vz [NC+1];
    logic [1:0] uq [NC+1], vq [NC+1];

    assign ux[0] = CORDIC_GAIN;
    assign uy[0] = '0;
    assign uz[0] = t_cval'({4'd0, w_uph[29:0]});
    assign uq[0] = w_uph[31:30];
    assign vx[0] = CORDIC_GAIN;
    assign vy[0] = '0;
    assign vz[0] = t_cval'({4'd0, w_vph[29:0]});
    assign vq[0] = w_vph[31:30];

    for (genvar k = 0; k < NC; k++) begin : g_cordic
        sgv_cordic_cell #(.STAGE(k)) u_ucell (
            .i_clk (i_clk), .i_en (w_en),
            .i_x (ux[k]), .i_y (uy[k]), .i_z (uz[k]), .i_quad (uq[k]),
            .o_x (ux[k+1]), .o_y (uy[k+1]), .o_z (uz[k+1]), .o_quad (uq[k+1])
        );
        sgv_cordic_cell #(.STAGE(k)) u_vcell (
            .i_clk (i_clk), .i_en (w_en),
            .i_x (vx[k]), .i_y (vy[k]), .i_z (vz[k]), .i_quad (vq[k]),
            .o_x (vx[k+1]), .o_y (vy[k+1]), .o_z (vz[k+1]), .o_quad (vq[k+1])
        );
    end

    logic [NC-1:0] r_cv;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cv <= '0;
        end else if (w_en) begin
            if (NC > 1)
                r_cv <= {r_cv[NC-2:0], r_dv[DIV_STEPS-1]};
            else
                r_cv <= r_dv[DIV_STEPS-1];
        end
    end

    function automatic logic signed [31:0] clamp30(input t_cval a);
        logic signed [31:0] c;
        if (a > t_cval'(ONE_Q30))
            c = ONE_Q30;
        else if (a < -t_cval'(ONE_Q30))
            c = -ONE_Q30;
        else
            c = a[31:0];
        return c;
    endfunction

    // Quadrant fold: returns {sin, cos}.
    function automatic logic [63:0] fold(input t_cval x, input t_cval y, input logic [1:0] q);
        logic signed [31:0] cx, cy, s, c;
        cx = clamp30(x);
        cy = clamp30(y);
        case (q)
            2'd0:    begin c = cx;  s = cy;  end
            2'd1:    begin c = -cy; s = cx;  end
            2'd2:    begin c = -cx; s = -cy; end
            default: begin c = cy;  s = -cx; end
        endcase
        return {s, c};
    endfunction

    // Post stages: fold, products, direction, scale, offset
    logic               r_p1_v, r_p2_v, r_p3_v, r_p4_v, r_p5_v;
    logic signed [31:0] r_su, r_cu, r_sv, r_cv_cos;
    logic signed [63:0] r_pdx, r_pdy;
    logic signed [31:0] r_cv2;
    logic signed [31:0] r_dx, r_dy, r_dz;
    logic signed [63:0] r_mx, r_my, r_mz;
    logic signed [15:0] r_nx4, r_ny4, r_nz4;
    logic signed [31:0] r_px, r_py, r_pz;
    logic signed [15:0] r_nx, r_ny, r_nz;

    logic [63:0] w_fu, w_fv;
    assign w_fu = fold(ux[NC], uy[NC], uq[NC]);
    assign w_fv = fold(vx[NC], vy[NC], vq[NC]);

    function automatic logic signed [31:0] rnd30_d(input logic signed [63:0] p);
        logic signed [63:0] t;
        t = (p + 64'sd536870912) >>> 30;
        return t[31:0];
    endfunction

    function automatic logic signed [15:0] norm16(input logic signed [31:0] d);
        logic signed [31:0] t;
        logic signed [15:0] n;
        t = (d + 32'sd32768) >>> 16;
        if (t > 32'sd16384)
            n = 16'sd16384;
        else if (t < -32'sd16384)
            n = -16'sd16384;
        else
            n = t[15:0];
        return n;
    endfunction

    function automatic logic signed [31:0] place(input logic signed [31:0] c,
                                                 input logic signed [63:0] m);
        logic signed [63:0] t;
        logic signed [35:0] sum;
        logic signed [31:0] p;
        t   = (m + 64'sd536870912) >>> 30;
        sum = $signed(t[35:0]) + 36'(c);
        if (sum > 36'sd2147483647)
            p = 32'sh7FFF_FFFF;
        else if (sum < -36'sd2147483648)
            p = 32'sh8000_0000;
        else
            p = sum[31:0];
        return p;
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p1_v <= 1'b0;
            r_p2_v <= 1'b0;
            r_p3_v <= 1'b0;
            r_p4_v <= 1'b0;
            r_p5_v <= 1'b0;
        end else if (w_en) begin
            r_p1_v <= r_cv[NC-1];
            r_p2_v <= r_p1_v;
            r_p3_v <= r_p2_v;
            r_p4_v <= r_p3_v;
            r_p5_v <= r_p4_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_su     <= w_fu[63:32];
            r_cu     <= w_fu[31:0];
            r_sv     <= w_fv[63:32];
            r_cv_cos <= w_fv[31:0];

            r_pdx <= r_sv * r_cu;
            r_pdy <= r_sv * r_su;
            r_cv2 <= r_cv_cos;

            r_dx <= rnd30_d(r_pdx);
            r_dy <= rnd30_d(r_pdy);
            r_dz <= r_cv2;

            r_mx  <= $signed({1'b0, r_radius}) * r_dx;
            r_my  <= $signed({1'b0, r_radius}) * r_dy;
            r_mz  <= $signed({1'b0, r_radius}) * r_dz;
            r_nx4 <= norm16(r_dx);
            r_ny4 <= norm16(r_dy);
            r_nz4 <= norm16(r_dz);

            r_px <= place(r_center_x, r_mx);
            r_py <= place(r_center_y, r_my);
            r_pz <= place(r_center_z, r_mz);
            r_nx <= r_nx4;
            r_ny <= r_ny4;
            r_nz <= r_nz4;
        end
    end

    // Output register with one skid entry behind it
    logic [143:0] w_res, r_out_d, r_sk_d;
    logic         w_pop, w_arrive;

    assign w_res    = {r_nz, r_ny, r_nx, r_pz, r_py, r_px};
    assign w_pop    = r_out_v && m_axis_tready;
    assign w_arrive = w_en && r_p5_v;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
            r_sk_v  <= 1'b0;
        end else if (r_sk_v) begin
            if (w_pop) begin
                r_out_d <= r_sk_d;
                r_sk_v  <= 1'b0;
            end
        end else if (w_arrive) begin
            if (!r_out_v || w_pop) begin
                r_out_d <= w_res;
                r_out_v <= 1'b1;
            end else begin
                r_sk_d <= w_res;
                r_sk_v <= 1'b1;
            end
        end else if (w_pop) begin
            r_out_v <= 1'b0;
        end
    end

    assign m_axis_tvalid = r_out_v;
    assign m_axis_tdata  = r_out_d;

endmodule
